>>> hdl/sgpl_pkg.sv
// Shared types and constants for the smoothed gain peak limiter.
package sgpl_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEFF_BITS_DEF  = 24;

  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 20;
  localparam int LIM_FRAC  = 23;
  localparam int THR_W     = 23;
  localparam int QUOT_W    = 24;

  localparam logic [GAIN_W-1:0] TARGET_RESET  = 24'd1048576;
  localparam logic [63:0]       SMOOTH_RESET  = 64'd16752000;
  localparam logic [63:0]       RELEASE_RESET = 64'd16770000;
  localparam logic [THR_W-1:0]  THR_RESET     = 23'd8388607;
  localparam logic [GAIN_W-1:0] LIM_ONE       = 24'd8388608;

  localparam logic [1:0] REG_TARGET_GAIN   = 2'd0;
  localparam logic [1:0] REG_SMOOTH_COEFF  = 2'd1;
  localparam logic [1:0] REG_RELEASE_COEFF = 2'd2;
  localparam logic [1:0] REG_THRESHOLD     = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SMOOTH,
    ST_SCALE,
    ST_PEAK,
    ST_CHECK,
    ST_DIV,
    ST_REL,
    ST_APPLY,
    ST_PACK
  } state_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic apply;
  } lane_ctrl_t;

  typedef struct packed {
    logic done;
    logic big;
  } div_stat_t;

endpackage

>>> hdl/sgpl_lane.sv
// One channel lane: magnitude split, gain scaling, limiter multiply and saturation.
module sgpl_lane #(
  parameter int SAMPLE_BITS = sgpl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  sgpl_pkg::lane_ctrl_t              ctrl,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  input  logic [sgpl_pkg::GAIN_W-1:0]       gain,
  input  logic [sgpl_pkg::GAIN_W-1:0]       lim_gain,
  output logic [SAMPLE_BITS+3:0]            smag,
  output logic signed [SAMPLE_BITS-1:0]     result
);

  localparam int SmagW  = SAMPLE_BITS + 4;
  localparam int OmagW  = SAMPLE_BITS + 5;
  localparam int ProdW  = SAMPLE_BITS + sgpl_pkg::GAIN_W;
  localparam int OProdW = SmagW + sgpl_pkg::GAIN_W;
  localparam logic [ProdW-1:0]  ScaleRnd = ProdW'(1) << (sgpl_pkg::GAIN_FRAC - 1);
  localparam logic [OProdW-1:0] LimRnd   = OProdW'(1) << (sgpl_pkg::LIM_FRAC - 1);
  localparam logic [OmagW-1:0]  NegLim   = OmagW'(1) << (SAMPLE_BITS - 1);
  localparam logic [OmagW-1:0]  PosLim   = NegLim - OmagW'(1);

  logic                   neg_r;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [SmagW-1:0]       smag_r;
  logic [OmagW-1:0]       omag_r;

  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] mag_nxt;
  logic [ProdW-1:0]       sprod;
  logic [OProdW-1:0]      oprod;

  assign raw     = sample;
  assign mag_nxt = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
  assign sprod   = ProdW'(mag_r) * ProdW'(gain) + ScaleRnd;
  assign oprod   = OProdW'(smag_r) * OProdW'(lim_gain) + LimRnd;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      neg_r <= raw[SAMPLE_BITS-1];
      mag_r <= mag_nxt;
    end
    if (ctrl.scale) begin
      smag_r <= sprod[ProdW-1:sgpl_pkg::GAIN_FRAC];
    end
    if (ctrl.apply) begin
      omag_r <= oprod[OProdW-1:sgpl_pkg::LIM_FRAC];
    end
  end

  assign smag = smag_r;

  always_comb begin
    if (neg_r) begin
      if (omag_r > NegLim) begin
        result = NegLim[SAMPLE_BITS-1:0];
      end else begin
        result = ~omag_r[SAMPLE_BITS-1:0] + 1'b1;
      end
    end else begin
      if (omag_r > PosLim) begin
        result = PosLim[SAMPLE_BITS-1:0];
      end else begin
        result = omag_r[SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

>>> hdl/sgpl_div.sv
// Radix-2 restoring divider for threshold over peak, with quotient overflow check.
module sgpl_div #(
  parameter int SAMPLE_BITS = sgpl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [sgpl_pkg::THR_W-1:0]      thr,
  input  logic [SAMPLE_BITS+3:0]          divisor,
  output sgpl_pkg::div_stat_t             stat,
  output logic [sgpl_pkg::QUOT_W-1:0]     quot
);

  localparam int DW   = SAMPLE_BITS + 4;
  localparam int QW   = sgpl_pkg::QUOT_W;
  localparam int NW   = sgpl_pkg::THR_W + SAMPLE_BITS - 1;
  localparam int CntW = $clog2(QW);

  logic            busy_r;
  logic            done_r;
  logic            big_r;
  logic [CntW-1:0] cnt_r;
  logic [DW-1:0]   rem_r;
  logic [QW-1:0]   lo_r;
  logic [QW-1:0]   q_r;

  logic [NW-1:0]   num;
  logic [DW-1:0]   hi;
  logic [DW:0]     shifted;
  logic            fits;

  assign num     = {thr, {(SAMPLE_BITS - 1){1'b0}}};
  assign hi      = DW'(num[NW-1:QW]);
  assign shifted = {rem_r, lo_r[QW-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (hi >= divisor) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == CntW'(QW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      big_r <= hi >= divisor;
      rem_r <= hi;
      lo_r  <= num[QW-1:0];
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? DW'(shifted - {1'b0, divisor}) : shifted[DW-1:0];
      lo_r  <= {lo_r[QW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign stat.done = done_r;
  assign stat.big  = big_r;
  assign quot      = q_r;

endmodule

>>> hdl/smoothed_gain_peak_limiter.sv
// Top level: config registers, gain smoother, limiter gain control and sequencing.
//
//   Channel | Ports                               | Handshake
//   --------+-------------------------------------+------------------
//   input   | in_left_sample, in_right_sample     | in_valid/in_stall
//   output  | out_left_out, out_right_out         | out_valid/out_stall
//   config  | cfg_index, cfg_wdata                | cfg_wr_en
//
// Each transaction steps through smooth, scale, peak, check, the 24-step ratio
// divider, an optional release step, apply and pack before the next acceptance.
// A zero peak skips the divider; a ratio overflow ends the divide without any steps.
// Lanes process left and right side by side; the peak merge feeds the divider.
// The result sits in an output register, so a stalled output does not block
// the next input transaction until that one is ready to leave.
// Reset (synchronous, rst_n low) loads register defaults and unity gains.
module smoothed_gain_peak_limiter #(
  parameter int SAMPLE_BITS = sgpl_pkg::SAMPLE_BITS_DEF,
  parameter int COEFF_BITS  = sgpl_pkg::COEFF_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0]                 in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0]                 in_right_sample,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]                 out_left_out,
  output logic signed [SAMPLE_BITS-1:0]                 out_right_out,
  input  logic                                          cfg_wr_en,
  input  logic [1:0]                                    cfg_index,
  input  logic [((COEFF_BITS > 24) ? COEFF_BITS : 24)-1:0] cfg_wdata
);

  localparam int GW   = sgpl_pkg::GAIN_W;
  localparam int SmW  = COEFF_BITS + GW + 2;
  localparam logic signed [SmW-1:0] CoefHalf = SmW'(1) << (COEFF_BITS - 1);
  localparam logic signed [SmW-1:0] RelBase  = SmW'(1) << (COEFF_BITS + sgpl_pkg::LIM_FRAC);

  sgpl_pkg::state_t state_r, state_nxt;

  logic [GW-1:0]               target_r;
  logic [COEFF_BITS-1:0]       smooth_coeff_r;
  logic [COEFF_BITS-1:0]       release_coeff_r;
  logic [sgpl_pkg::THR_W-1:0]  thr_r;
  logic [GW-1:0]               sm_r;
  logic [GW-1:0]               lg_r;
  logic [SAMPLE_BITS+3:0]      peak_r;
  logic                        out_valid_r;
  logic [SAMPLE_BITS-1:0]      out_left_r;
  logic [SAMPLE_BITS-1:0]      out_right_r;

  sgpl_pkg::lane_ctrl_t        lane_ctrl;
  sgpl_pkg::div_stat_t         div_stat;
  logic                        div_start;
  logic [sgpl_pkg::QUOT_W-1:0] div_quot;
  logic [SAMPLE_BITS+3:0]      left_smag;
  logic [SAMPLE_BITS+3:0]      right_smag;
  logic signed [SAMPLE_BITS-1:0] left_res;
  logic signed [SAMPLE_BITS-1:0] right_res;

  logic                        in_accept;
  logic                        out_free;
  logic signed [GW:0]          sm_diff;
  logic signed [SmW-1:0]       sm_sum;
  logic [GW-1:0]               sm_nxt;
  logic signed [GW:0]          rel_diff;
  logic signed [SmW-1:0]       rel_sum;
  logic [GW-1:0]               rel_nxt;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign sm_diff = $signed({1'b0, sm_r}) - $signed({1'b0, target_r});
  assign sm_sum  = $signed({2'b00, target_r, {COEFF_BITS{1'b0}}})
                 + $signed({1'b0, smooth_coeff_r}) * sm_diff + CoefHalf;
  assign sm_nxt  = sm_sum[COEFF_BITS+GW-1:COEFF_BITS];

  assign rel_diff = $signed({1'b0, lg_r}) - $signed({1'b0, sgpl_pkg::LIM_ONE});
  assign rel_sum  = RelBase + $signed({1'b0, release_coeff_r}) * rel_diff + CoefHalf;
  assign rel_nxt  = rel_sum[COEFF_BITS+GW-1:COEFF_BITS];

  sgpl_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
    .clk      (clk),
    .ctrl     (lane_ctrl),
    .sample   (in_left_sample),
    .gain     (sm_r),
    .lim_gain (lg_r),
    .smag     (left_smag),
    .result   (left_res)
  );

  sgpl_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
    .clk      (clk),
    .ctrl     (lane_ctrl),
    .sample   (in_right_sample),
    .gain     (sm_r),
    .lim_gain (lg_r),
    .smag     (right_smag),
    .result   (right_res)
  );

  sgpl_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .thr     (thr_r),
    .divisor (peak_r),
    .stat    (div_stat),
    .quot    (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sgpl_pkg::ST_IDLE:   if (in_accept) state_nxt = sgpl_pkg::ST_SMOOTH;
      sgpl_pkg::ST_SMOOTH: state_nxt = sgpl_pkg::ST_SCALE;
      sgpl_pkg::ST_SCALE:  state_nxt = sgpl_pkg::ST_PEAK;
      sgpl_pkg::ST_PEAK:   state_nxt = sgpl_pkg::ST_CHECK;
      sgpl_pkg::ST_CHECK: begin
        state_nxt = (peak_r == '0) ? sgpl_pkg::ST_REL : sgpl_pkg::ST_DIV;
      end
      sgpl_pkg::ST_DIV: begin
        if (div_stat.done) begin
          if (div_stat.big || div_quot >= lg_r) begin
            state_nxt = sgpl_pkg::ST_REL;
          end else begin
            state_nxt = sgpl_pkg::ST_APPLY;
          end
        end
      end
      sgpl_pkg::ST_REL:    state_nxt = sgpl_pkg::ST_APPLY;
      sgpl_pkg::ST_APPLY:  state_nxt = sgpl_pkg::ST_PACK;
      sgpl_pkg::ST_PACK:   if (out_free) state_nxt = sgpl_pkg::ST_IDLE;
      default:             state_nxt = sgpl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    div_start       = 1'b0;
    lane_ctrl.load  = 1'b0;
    lane_ctrl.scale = 1'b0;
    lane_ctrl.apply = 1'b0;
    unique case (state_r)
      sgpl_pkg::ST_IDLE: begin
        in_stall       = 1'b0;
        lane_ctrl.load = in_valid;
      end
      sgpl_pkg::ST_SCALE: lane_ctrl.scale = 1'b1;
      sgpl_pkg::ST_CHECK: div_start = peak_r != '0;
      sgpl_pkg::ST_APPLY: lane_ctrl.apply = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= sgpl_pkg::ST_IDLE;
      target_r        <= sgpl_pkg::TARGET_RESET;
      smooth_coeff_r  <= sgpl_pkg::SMOOTH_RESET[COEFF_BITS-1:0];
      release_coeff_r <= sgpl_pkg::RELEASE_RESET[COEFF_BITS-1:0];
      thr_r           <= sgpl_pkg::THR_RESET;
      sm_r            <= sgpl_pkg::TARGET_RESET;
      lg_r            <= sgpl_pkg::LIM_ONE;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          sgpl_pkg::REG_TARGET_GAIN:   target_r        <= cfg_wdata[GW-1:0];
          sgpl_pkg::REG_SMOOTH_COEFF:  smooth_coeff_r  <= cfg_wdata[COEFF_BITS-1:0];
          sgpl_pkg::REG_RELEASE_COEFF: release_coeff_r <= cfg_wdata[COEFF_BITS-1:0];
          sgpl_pkg::REG_THRESHOLD:     thr_r           <= cfg_wdata[sgpl_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (state_r == sgpl_pkg::ST_SMOOTH) begin
        sm_r <= sm_nxt;
      end
      if (state_r == sgpl_pkg::ST_REL) begin
        lg_r <= rel_nxt;
      end else if (state_r == sgpl_pkg::ST_DIV && div_stat.done && !div_stat.big
                   && div_quot < lg_r) begin
        lg_r <= div_quot;
      end
      if (state_r == sgpl_pkg::ST_PACK && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sgpl_pkg::ST_PEAK) begin
      peak_r <= (left_smag > right_smag) ? left_smag : right_smag;
    end
    if (state_r == sgpl_pkg::ST_PACK && out_free) begin
      out_left_r  <= left_res;
      out_right_r <= right_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

endmodule

>>> bench/limiter_checker.sv
// Checker for the smoothed gain peak limiter: tracks registers, predicts and compares frames.
`timescale 1ns / 1ps

module limiter_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic [sgpl_pkg::SAMPLE_BITS_DEF-1:0]   in_left_sample,
  input  logic [sgpl_pkg::SAMPLE_BITS_DEF-1:0]   in_right_sample,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic [sgpl_pkg::SAMPLE_BITS_DEF-1:0]   out_left_out,
  input  logic [sgpl_pkg::SAMPLE_BITS_DEF-1:0]   out_right_out,
  input  logic                                   cfg_wr_en,
  input  logic [1:0]                             cfg_index,
  input  logic [((sgpl_pkg::COEFF_BITS_DEF > 24) ? sgpl_pkg::COEFF_BITS_DEF : 24)-1:0] cfg_wdata,
  output int                                     fail_count,
  output int                                     frames_in_flight
);
  import sgpl_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int CW = COEFF_BITS_DEF;

  typedef struct packed {
    logic [SW-1:0] left;
    logic [SW-1:0] right;
  } frame_t;

  frame_t limited_frames[$];
  frame_t want;

  logic [GAIN_W-1:0] tgt_gain;
  logic [CW-1:0]     smooth_pole;
  logic [CW-1:0]     release_pole;
  logic [THR_W-1:0]  ceiling;
  logic [GAIN_W-1:0] run_gain;
  logic [GAIN_W-1:0] lim_gain;

  initial begin
    fail_count = 0;
    frames_in_flight = 0;
  end

  function automatic logic [63:0] magnitude(logic [SW-1:0] raw);
    if (raw[SW-1])
      return (64'd1 << SW) - 64'(raw);
    return 64'(raw);
  endfunction

  function automatic logic [SW-1:0] saturate(logic [63:0] mag, logic neg);
    logic [63:0] word;
    if (neg) begin
      if (mag > (64'd1 << (SW-1)))
        mag = 64'd1 << (SW-1);
      word = (64'd1 << SW) - mag;
    end else begin
      if (mag > (64'd1 << (SW-1)) - 64'd1)
        mag = (64'd1 << (SW-1)) - 64'd1;
      word = mag;
    end
    return word[SW-1:0];
  endfunction

  // Advances both gains by one frame and returns the limited output frame.
  function automatic frame_t limit_frame(logic [SW-1:0] l, logic [SW-1:0] r);
    logic [63:0] one;
    logic [63:0] acc;
    logic [63:0] lmag;
    logic [63:0] rmag;
    logic [63:0] peak;
    logic [63:0] ratio;
    logic        drop;
    frame_t      f;
    one = 64'd1 << CW;
    acc = (64'(smooth_pole) * 64'(run_gain) + (one - 64'(smooth_pole)) * 64'(tgt_gain)
           + (one >> 1)) >> CW;
    run_gain = acc[GAIN_W-1:0];

    lmag = (magnitude(l) * 64'(run_gain) + (64'd1 << (GAIN_FRAC-1))) >> GAIN_FRAC;
    rmag = (magnitude(r) * 64'(run_gain) + (64'd1 << (GAIN_FRAC-1))) >> GAIN_FRAC;
    peak = (lmag > rmag) ? lmag : rmag;

    drop = 1'b0;
    ratio = 64'd0;
    if (peak != 64'd0) begin
      ratio = (64'(ceiling) << (SW-1)) / peak;
      drop = ratio < 64'(lim_gain);
    end
    if (drop) begin
      lim_gain = ratio[GAIN_W-1:0];
    end else begin
      acc = (64'(release_pole) * 64'(lim_gain) + (one - 64'(release_pole)) * 64'(LIM_ONE)
             + (one >> 1)) >> CW;
      if (acc > 64'(LIM_ONE))
        acc = 64'(LIM_ONE);
      lim_gain = acc[GAIN_W-1:0];
    end

    lmag = (lmag * 64'(lim_gain) + (64'd1 << (LIM_FRAC-1))) >> LIM_FRAC;
    rmag = (rmag * 64'(lim_gain) + (64'd1 << (LIM_FRAC-1))) >> LIM_FRAC;
    f.left  = saturate(lmag, l[SW-1]);
    f.right = saturate(rmag, r[SW-1]);
    return f;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tgt_gain     = TARGET_RESET;
      smooth_pole  = SMOOTH_RESET[CW-1:0];
      release_pole = RELEASE_RESET[CW-1:0];
      ceiling      = THR_RESET;
      run_gain     = TARGET_RESET;
      lim_gain     = LIM_ONE;
      limited_frames.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (limited_frames.size() == 0) begin
          fail_count++;
          $display("%0t: output transaction with none pending: left %0d right %0d", $time,
                   $signed(out_left_out), $signed(out_right_out));
        end else begin
          want = limited_frames.pop_front();
          if (out_left_out !== want.left) begin
            fail_count++;
            $display("%0t: left_out expected %0d, actual %0d", $time,
                     $signed(want.left), $signed(out_left_out));
          end
          if (out_right_out !== want.right) begin
            fail_count++;
            $display("%0t: right_out expected %0d, actual %0d", $time,
                     $signed(want.right), $signed(out_right_out));
          end
        end
      end
      if (in_valid && !in_stall)
        limited_frames.push_back(limit_frame(in_left_sample, in_right_sample));
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TARGET_GAIN:   tgt_gain = cfg_wdata[GAIN_W-1:0];
          REG_SMOOTH_COEFF:  smooth_pole = cfg_wdata[CW-1:0];
          REG_RELEASE_COEFF: release_pole = cfg_wdata[CW-1:0];
          REG_THRESHOLD:     ceiling = cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
    end
    frames_in_flight = limited_frames.size();
  end

endmodule

>>> bench/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the smoothed gain peak limiter.
`timescale 1ns / 1ps

module testbench;
  import sgpl_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int DW = (COEFF_BITS_DEF > 24) ? COEFF_BITS_DEF : 24;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 64;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_FRAMES = 150;
  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [SW-1:0] in_left_sample;
  logic [SW-1:0] in_right_sample;
  logic          out_valid;
  logic          out_stall;
  logic [SW-1:0] out_left_out;
  logic [SW-1:0] out_right_out;
  logic          cfg_wr_en;
  logic [1:0]    cfg_index;
  logic [DW-1:0] cfg_wdata;

  int fail_count;
  int frames_in_flight;
  int cycles = 0;
  bit calm = 1'b0;

  smoothed_gain_peak_limiter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  limiter_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_left_sample   (in_left_sample),
    .in_right_sample  (in_right_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left_out     (out_left_out),
    .out_right_out    (out_right_out),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .frames_in_flight (frames_in_flight)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [SW-1:0] rand_sample(int shift);
    logic [31:0]          w;
    logic signed [SW-1:0] s;
    int                   r;
    w = $urandom;
    s = w[SW-1:0];
    r = $urandom_range(0, 15);
    case (r)
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      default: return s >>> shift;
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_reg(logic [1:0] idx);
    logic [31:0] w;
    int          r;
    w = $urandom;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES;
    case (idx)
      REG_TARGET_GAIN:   return DW'($urandom_range(1 << 18, 3 << 20));
      REG_SMOOTH_COEFF,
      REG_RELEASE_COEFF: return (r == 2) ? w[DW-1:0] : ALL_ONES - DW'($urandom_range(0, 1 << 16));
      default:           return w[DW-1:0];
    endcase
  endfunction

  task automatic send_frame(input logic [SW-1:0] l, input logic [SW-1:0] r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        = 1'b1;
    in_left_sample  = l;
    in_right_sample = r;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds the sender off until every pending transaction has left the block.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (frames_in_flight != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DW-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic configure(input logic [DW-1:0] tg, input logic [DW-1:0] sc,
                           input logic [DW-1:0] rc, input logic [DW-1:0] th);
    drain();
    write_reg(REG_TARGET_GAIN, tg);
    write_reg(REG_SMOOTH_COEFF, sc);
    write_reg(REG_RELEASE_COEFF, rc);
    write_reg(REG_THRESHOLD, th);
  endtask

  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall = 1'b1;
        hold--;
      end else begin
        out_stall = 1'b0;
        hold = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end
    end
  end

  initial begin
    int remaining;
    int seg;
    int shift;
    in_valid        = 1'b0;
    in_left_sample  = '0;
    in_right_sample = '0;
    cfg_wr_en       = 1'b0;
    cfg_index       = REG_TARGET_GAIN;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: silence, full scale both polarities, smallest steps
    send_frame('0, '0);
    send_frame(S_MAX, S_MAX);
    send_frame(S_MIN, S_MIN);
    send_frame(S_MAX, S_MIN);
    send_frame(S_MIN, S_MAX);
    send_frame(SW'(1), ALL_ONES[SW-1:0]);
    send_frame('0, SW'(24'h400000));
    send_frame('0, '0);

    // max gain, instant smoothing and release: hard limiting and saturation
    configure(ALL_ONES, '0, '0, DW'(THR_RESET));
    send_frame(S_MAX, '0);
    send_frame(S_MIN, SW'(1));
    send_frame('0, '0);
    send_frame(SW'(24'h000100), SW'(24'hFFFF00));
    send_frame(SW'(1), SW'(1));

    // zero threshold
    configure(DW'(1 << GAIN_FRAC), '0, ALL_ONES, '0);
    send_frame(SW'(24'h400000), SW'(24'hC00000));
    send_frame('0, '0);
    send_frame(SW'(1), '0);
    send_frame(S_MAX, S_MIN);

    // zero target gain; threshold write with its unused top bit set
    configure('0, '0, DW'(24'h800000), ALL_ONES);
    send_frame(S_MAX, S_MIN);
    send_frame(SW'(24'h123456), SW'(24'h654321));

    // slowest poles
    configure(DW'(2 << GAIN_FRAC), ALL_ONES, ALL_ONES, DW'(24'h200000));
    send_frame(SW'(24'h600000), SW'(24'hA00000));
    send_frame('0, '0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure(rand_reg(REG_TARGET_GAIN), rand_reg(REG_SMOOTH_COEFF),
                rand_reg(REG_RELEASE_COEFF), rand_reg(REG_THRESHOLD));
      remaining = PHASE_FRAMES;
      while (remaining > 0) begin
        seg = $urandom_range(10, 60);
        if (seg > remaining)
          seg = remaining;
        calm  = ($urandom_range(0, 4) == 0);
        shift = $urandom_range(0, 16);
        for (int i = 0; i < seg; i++)
          send_frame(rand_sample(shift), rand_sample(shift));
        remaining -= seg;
      end
      calm = 1'b0;
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && frames_in_flight == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
